FILE: rtl/uff_pkg.sv
`default_nettype none

package uff_pkg;

  localparam int DEFAULT_FIFO_DEPTH = 64;

  localparam int OP_W = 2;
  localparam int DATA_W = 8;
  localparam int LEVEL_W = 6;
  localparam int THRESH_W = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam int FLAGS_W = 3;

  // Event codes
  localparam logic [OP_W-1:0] OP_RX_BYTE  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP      = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd2;
  localparam logic [OP_W-1:0] OP_TX_READY = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_ENABLE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_THRESHOLD = 2'd1;

  localparam logic                RESET_FLOW_ENABLE    = 1'b1;
  localparam logic [THRESH_W-1:0] RESET_FLOW_THRESHOLD = 6'd16;

  // Flow control flag bits
  localparam int FLAG_SEND_XON  = 0;
  localparam int FLAG_SEND_XOFF = 1;
  localparam int FLAG_STATE_XON = 2;

  localparam logic [FLAGS_W-1:0] FLAGS_RESET = 3'b001;

  localparam logic [DATA_W-1:0] BYTE_XON  = 8'd17;
  localparam logic [DATA_W-1:0] BYTE_XOFF = 8'd19;

  typedef struct packed {
    logic capture;
    logic commit;
  } uff_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/uff_ram.sv
`default_nettype none

module uff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/uff_ctrl.sv
`default_nettype none

module uff_ctrl
  import uff_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  wire      out_ready,
  output uff_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // Execute only when the output slot is free or being emptied this cycle
  assign cmd.commit  = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_fills_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after execute");

  a_capture_commit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.capture && cmd.commit))
    else $error("capture and execute in the same cycle");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && out_valid && !out_ready |=> (state == S_EXEC) && !in_ready)
    else $error("event executed while output slot was full");
`endif

endmodule

`default_nettype wire

FILE: rtl/uff_dp.sv
`default_nettype none

module uff_dp
  import uff_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire uff_cmd_t          cmd,
  input  wire [OP_W-1:0]         op,
  input  wire [DATA_W-1:0]       byte_in,
  input  wire                    cfg_we,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data,
  output logic [DATA_W-1:0]      byte_out,
  output logic                   byte_valid,
  output logic                   accepted,
  output logic [LEVEL_W-1:0]     rx_level,
  output logic [LEVEL_W-1:0]     tx_level,
  output logic                   tx_request
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int FW = PW + 1;
  localparam int CW = (FW > THRESH_W) ? FW : THRESH_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F  = FW'(FIFO_DEPTH);
  localparam logic [FW-1:0] USABLE   = FW'(FIFO_DEPTH - 1);

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [FW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
    return (w >= r) ? ({1'b0, w} - {1'b0, r}) : ({1'b0, w} + DEPTH_F - {1'b0, r});
  endfunction

  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   byte_q;
  logic                flow_enable;
  logic [THRESH_W-1:0] flow_threshold;
  logic [PW-1:0]       rx_wp, rx_rp, tx_wp, tx_rp;
  logic [PW-1:0]       rx_wp_next, rx_rp_next, tx_wp_next, tx_rp_next;
  logic [FLAGS_W-1:0]  flags, flags_next;
  logic                tx_wanted, tx_wanted_next;
  logic [DATA_W-1:0]   rx_rdata, tx_rdata;
  logic                rx_we, tx_we;

  logic [FW-1:0]       rx_fill, tx_fill, rx_fill_after, tx_fill_after;
  logic [CW-1:0]       thresh_ext, rx_free_ext, rx_fill_ext, tx_fill_ext;
  logic [DATA_W-1:0]   res_byte;
  logic                res_valid, res_acc;

  uff_ram #(.WIDTH(DATA_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_wp), .wdata(byte_q), .raddr(rx_rp), .rdata(rx_rdata)
  );

  uff_ram #(.WIDTH(DATA_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_wp), .wdata(byte_q), .raddr(tx_rp), .rdata(tx_rdata)
  );

  assign rx_fill    = fill_of(rx_wp, rx_rp);
  assign tx_fill    = fill_of(tx_wp, tx_rp);
  assign thresh_ext = CW'(flow_threshold);

  always_comb begin
    rx_wp_next     = rx_wp;
    rx_rp_next     = rx_rp;
    tx_wp_next     = tx_wp;
    tx_rp_next     = tx_rp;
    flags_next     = flags;
    tx_wanted_next = tx_wanted;
    res_byte       = '0;
    res_valid      = 1'b0;
    res_acc        = 1'b0;
    rx_fill_after  = rx_fill;
    tx_fill_after  = tx_fill;
    rx_free_ext    = '0;
    rx_we          = 1'b0;
    tx_we          = 1'b0;
    unique case (op_q)
      OP_RX_BYTE: begin
        if (rx_fill < USABLE) begin
          rx_we         = cmd.commit;
          rx_wp_next    = ptr_next(rx_wp);
          rx_fill_after = rx_fill + 1'b1;
          res_acc       = 1'b1;
        end
        rx_free_ext = CW'(USABLE - rx_fill_after);
        if (flow_enable && flags[FLAG_STATE_XON] && (rx_free_ext <= thresh_ext)) begin
          flags_next                 = '0;
          flags_next[FLAG_SEND_XOFF] = 1'b1;
          flags_next[FLAG_STATE_XON] = 1'b1;
          tx_wanted_next             = 1'b1;
        end
      end
      OP_POP: begin
        if (rx_fill != '0) begin
          res_byte      = rx_rdata;
          res_valid     = 1'b1;
          rx_rp_next    = ptr_next(rx_rp);
          rx_fill_after = rx_fill - 1'b1;
        end
        if (flow_enable && !flags[FLAG_STATE_XON] &&
            (CW'(rx_fill_after) <= thresh_ext)) begin
          flags_next                = '0;
          flags_next[FLAG_SEND_XON] = 1'b1;
          tx_wanted_next            = 1'b1;
        end
      end
      OP_WRITE: begin
        if (tx_fill < USABLE) begin
          tx_we         = cmd.commit;
          tx_wp_next    = ptr_next(tx_wp);
          tx_fill_after = tx_fill + 1'b1;
          res_acc       = 1'b1;
        end
        tx_wanted_next = 1'b1;
      end
      OP_TX_READY: begin
        priority if (flow_enable && flags[FLAG_SEND_XON]) begin
          res_byte                   = BYTE_XON;
          res_valid                  = 1'b1;
          flags_next                 = '0;
          flags_next[FLAG_STATE_XON] = 1'b1;
        end else if (flow_enable && flags[FLAG_SEND_XOFF]) begin
          res_byte   = BYTE_XOFF;
          res_valid  = 1'b1;
          flags_next = '0;
        end else if (tx_fill != '0) begin
          res_byte      = tx_rdata;
          res_valid     = 1'b1;
          tx_rp_next    = ptr_next(tx_rp);
          tx_fill_after = tx_fill - 1'b1;
        end else begin
          tx_wanted_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign rx_fill_ext = CW'(rx_fill_after);
  assign tx_fill_ext = CW'(tx_fill_after);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      byte_q <= byte_in;
    end
    if (cmd.commit) begin
      byte_out   <= res_byte;
      byte_valid <= res_valid;
      accepted   <= res_acc;
      rx_level   <= rx_fill_ext[LEVEL_W-1:0];
      tx_level   <= tx_fill_ext[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp          <= '0;
      rx_rp          <= '0;
      tx_wp          <= '0;
      tx_rp          <= '0;
      flags          <= FLAGS_RESET;
      tx_wanted      <= 1'b1;
      tx_request     <= 1'b1;
      flow_enable    <= RESET_FLOW_ENABLE;
      flow_threshold <= RESET_FLOW_THRESHOLD;
    end else begin
      if (cmd.commit) begin
        rx_wp      <= rx_wp_next;
        rx_rp      <= rx_rp_next;
        tx_wp      <= tx_wp_next;
        tx_rp      <= tx_rp_next;
        flags      <= flags_next;
        tx_wanted  <= tx_wanted_next;
        tx_request <= tx_wanted_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FLOW_ENABLE:    flow_enable    <= cfg_data[0];
          CFG_FLOW_THRESHOLD: flow_threshold <= cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/uart_fifo_xon_xoff.sv
`default_nettype none

// Serial buffer with a receive FIFO and a transmit FIFO (FIFO_DEPTH-1 usable
// bytes each) and XON/XOFF flow control of the receive side. Each transfer on
// the input channel is one event (line byte received, host pop, host write,
// transmitter ready) and yields exactly one result transfer carrying the
// popped or sent byte, the store/drop flag, both fill levels and the
// transmit request. Each event is first taken while the FIFO memories read
// the byte at each read pointer, then executed against that registered read
// data to update pointers and flags. The next event is taken the cycle after
// execution, while the result may still wait in the output register;
// execution holds only while that register is full and not being taken.
// Configuration writes are taken in any cycle (cfg_ready is always high) and
// belong in quiet periods with no event in flight. FIFO contents need no
// clearing after reset; only the pointers, flags, transmit request and
// registers reset.
module uart_fifo_xon_xoff
  import uff_pkg::*;
#(
  parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
  input  wire                    clk,
  input  wire                    rst,
  // event channel
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [OP_W-1:0]         op,
  input  wire [DATA_W-1:0]       byte_in,
  // result channel
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [DATA_W-1:0]      byte_out,
  output logic                   byte_valid,
  output logic                   accepted,
  output logic [LEVEL_W-1:0]     rx_level,
  output logic [LEVEL_W-1:0]     tx_level,
  output logic                   tx_request,
  // configuration write channel
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_INDEX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data
);

  uff_cmd_t cmd;

  // Registers are plain flops: take every configuration transfer at once
  assign cfg_ready = 1'b1;

  // Sequence each event: take it, then execute once the output slot frees
  uff_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // FIFO memories, pointers, flow flags and the result register
  uff_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .op         (op),
    .byte_in    (byte_in),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_out   (byte_out),
    .byte_valid (byte_valid),
    .accepted   (accepted),
    .rx_level   (rx_level),
    .tx_level   (tx_level),
    .tx_request (tx_request)
  );

endmodule

`default_nettype wire

FILE: verif/uff_checker.sv
`timescale 1ns / 100ps

// Watches the event, result and register channels of the serial buffer.
// Keeps its own copy of both FIFOs, the flow flags and the registers, and
// compares every result transfer against the oldest expected status.
module uff_checker
  import uff_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire                   in_ready,
  input  wire [OP_W-1:0]        op,
  input  wire [DATA_W-1:0]      byte_in,
  input  wire                   out_valid,
  input  wire                   out_ready,
  input  wire [DATA_W-1:0]      byte_out,
  input  wire                   byte_valid,
  input  wire                   accepted,
  input  wire [LEVEL_W-1:0]     rx_level,
  input  wire [LEVEL_W-1:0]     tx_level,
  input  wire                   tx_request,
  input  wire                   cfg_valid,
  input  wire                   cfg_ready,
  input  wire [CFG_INDEX_W-1:0] cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int DEPTH = DEFAULT_FIFO_DEPTH;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [DATA_W-1:0]  byte_out;
    logic               byte_valid;
    logic               accepted;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               tx_request;
  } status_t;

  logic [DATA_W-1:0]  rx_mem [DEPTH];
  logic [DATA_W-1:0]  tx_mem [DEPTH];
  int                 rx_wr, rx_rd, tx_wr, tx_rd;
  logic [FLAGS_W-1:0] flags;
  logic               tx_want;
  logic               flow_en;
  logic [THRESH_W-1:0] flow_th;
  status_t            due_status [$];
  int                 mismatches = 0;
  int                 waiting = 0;

  assign fail_count = mismatches;
  assign pending = waiting;

  function automatic int fill(int w, int r);
    return (w - r + DEPTH) % DEPTH;
  endfunction

  function automatic int bump(int p);
    return (p + 1) % DEPTH;
  endfunction

  // Apply one event to the shadow buffer and return the status it yields.
  function automatic status_t buffer_event(logic [OP_W-1:0] kind, logic [DATA_W-1:0] data);
    status_t s;
    s = '0;
    case (kind)
      OP_RX_BYTE: begin
        if (fill(rx_wr, rx_rd) < DEPTH - 1) begin
          rx_mem[rx_wr] = data;
          rx_wr = bump(rx_wr);
          s.accepted = 1'b1;
        end
        if (flow_en && flags[FLAG_STATE_XON] &&
            (DEPTH - 1 - fill(rx_wr, rx_rd)) <= int'(flow_th)) begin
          flags = '0;
          flags[FLAG_SEND_XOFF] = 1'b1;
          flags[FLAG_STATE_XON] = 1'b1;
          tx_want = 1'b1;
        end
      end
      OP_POP: begin
        if (fill(rx_wr, rx_rd) != 0) begin
          s.byte_out = rx_mem[rx_rd];
          s.byte_valid = 1'b1;
          rx_rd = bump(rx_rd);
        end
        if (flow_en && !flags[FLAG_STATE_XON] && fill(rx_wr, rx_rd) <= int'(flow_th)) begin
          flags = '0;
          flags[FLAG_SEND_XON] = 1'b1;
          tx_want = 1'b1;
        end
      end
      OP_WRITE: begin
        if (fill(tx_wr, tx_rd) < DEPTH - 1) begin
          tx_mem[tx_wr] = data;
          tx_wr = bump(tx_wr);
          s.accepted = 1'b1;
        end
        tx_want = 1'b1;
      end
      OP_TX_READY: begin
        if (flow_en && flags[FLAG_SEND_XON]) begin
          s.byte_out = BYTE_XON;
          s.byte_valid = 1'b1;
          flags = '0;
          flags[FLAG_STATE_XON] = 1'b1;
        end else if (flow_en && flags[FLAG_SEND_XOFF]) begin
          s.byte_out = BYTE_XOFF;
          s.byte_valid = 1'b1;
          flags = '0;
        end else if (fill(tx_wr, tx_rd) != 0) begin
          s.byte_out = tx_mem[tx_rd];
          s.byte_valid = 1'b1;
          tx_rd = bump(tx_rd);
        end else begin
          tx_want = 1'b0;
        end
      end
    endcase
    s.rx_level = LEVEL_W'(fill(rx_wr, rx_rd));
    s.tx_level = LEVEL_W'(fill(tx_wr, tx_rd));
    s.tx_request = tx_want;
    return s;
  endfunction

  task automatic report(string what, status_t want, status_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t %s: expected byte=%02h bv=%0b acc=%0b rx=%0d tx=%0d req=%0b",
               $time, what, want.byte_out, want.byte_valid, want.accepted,
               want.rx_level, want.tx_level, want.tx_request);
      $display("%0t %s:   actual byte=%02h bv=%0b acc=%0b rx=%0d tx=%0d req=%0b",
               $time, what, got.byte_out, got.byte_valid, got.accepted,
               got.rx_level, got.tx_level, got.tx_request);
    end
  endtask

  always @(posedge clk) begin : monitor
    status_t got;
    status_t want;
    if (rst) begin
      rx_wr = 0;
      rx_rd = 0;
      tx_wr = 0;
      tx_rd = 0;
      flags = FLAGS_RESET;
      tx_want = 1'b1;
      flow_en = RESET_FLOW_ENABLE;
      flow_th = RESET_FLOW_THRESHOLD;
      due_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FLOW_ENABLE:    flow_en = cfg_data[0];
          CFG_FLOW_THRESHOLD: flow_th = cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        due_status.push_back(buffer_event(op, byte_in));
      end
      if (out_valid && out_ready) begin
        got = '{byte_out, byte_valid, accepted, rx_level, tx_level, tx_request};
        if (due_status.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = due_status.pop_front();
          // packed compare covers every field, X and Z included
          if (got !== want) begin
            report("mismatch", want, got);
          end
        end
      end
    end
    waiting = due_status.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the serial buffer. Events go in through the
// valid/ready event channel, results drain through the result channel, and
// uff_checker does all prediction and comparison beside the block.
module tb;
  import uff_pkg::*;

  // Longest stretch with no transfer on any channel before giving up. The
  // slowest correct run idles for the longest sender gap plus the longest
  // result stall and the pipeline's own delay, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 180;

  // Indexes past the register list: writes there must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum int {
    MIX_EVEN,
    MIX_RX_FILL,
    MIX_RX_DRAIN,
    MIX_TX_FILL,
    MIX_TX_DRAIN
  } mix_t;

  // Register settings per phase; enable data carries upper bits on purpose
  // so that masking to one bit is exercised (3E -> off, 3F -> on).
  localparam logic [CFG_DATA_W-1:0] ENABLE_SET [PHASES] = '{6'h01, 6'h01, 6'h01, 6'h3E, 6'h3F, 6'h01};
  localparam logic [CFG_DATA_W-1:0] THRESH_SET [PHASES] = '{6'd16, 6'd63, 6'd0, 6'd40, 6'd5, 6'd31};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [OP_W-1:0]        op = OP_RX_BYTE;
  logic [DATA_W-1:0]      byte_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [DATA_W-1:0]      byte_out;
  logic                   byte_valid;
  logic                   accepted;
  logic [LEVEL_W-1:0]     rx_level;
  logic [LEVEL_W-1:0]     tx_level;
  logic                   tx_request;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_FLOW_ENABLE;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;
  int                     idle_cycles = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  uart_fifo_xon_xoff i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_out   (byte_out),
    .byte_valid (byte_valid),
    .accepted   (accepted),
    .rx_level   (rx_level),
    .tx_level   (tx_level),
    .tx_request (tx_request),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  uff_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_out   (byte_out),
    .byte_valid (byte_valid),
    .accepted   (accepted),
    .rx_level   (rx_level),
    .tx_level   (tx_level),
    .tx_request (tx_request),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: restart the count on any transfer, bail out when it runs dry.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, a few long ones, and
  // now and then a long stretch that takes every result at once.
  initial begin : result_stalls
    int r;
    int lo;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        repeat ($urandom_range(50, 150)) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end else begin
        lo = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat ($urandom_range(1, 4)) begin
          @(negedge clk);
          out_ready <= 1'b1;
        end
        repeat (lo) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Sender gap: mostly back to back, some short pauses, rare long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Bias the event mix so the FIFOs actually reach full and empty and the
  // flow thresholds get crossed in both directions.
  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    logic [OP_W-1:0] main;
    case (mix)
      MIX_RX_FILL:  main = OP_RX_BYTE;
      MIX_RX_DRAIN: main = OP_POP;
      MIX_TX_FILL:  main = OP_WRITE;
      default:      main = OP_TX_READY;
    endcase
    if (mix != MIX_EVEN && $urandom_range(0, 99) < 82) return main;
    case ($urandom_range(0, 3))
      0:       return OP_RX_BYTE;
      1:       return OP_POP;
      2:       return OP_WRITE;
      default: return OP_TX_READY;
    endcase
  endfunction

  // Present one event after an optional gap, hold it until the transfer.
  task automatic send_event(input logic [OP_W-1:0] kind, input logic [DATA_W-1:0] data,
                            input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op <= kind;
    byte_in <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, let every expected result drain, then give the pipeline a
  // few extra cycles so no event is still in flight.
  task automatic drain(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic random_events(input int count);
    int sent;
    int burst;
    bit gaps_on;
    mix_t mix;
    sent = 0;
    while (sent < count) begin
      mix = mix_t'($urandom_range(0, 4));
      burst = (mix == MIX_EVEN) ? $urandom_range(20, 60) : $urandom_range(40, 130);
      // roughly one burst in five runs with no sender gaps at all
      gaps_on = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_event(pick_op(mix), DATA_W'($urandom_range(0, 255)), gaps_on ? pick_gap() : 0);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with the block idle
      if (ph != 0) drain(4);
      write_reg(CFG_FLOW_ENABLE, ENABLE_SET[ph]);
      write_reg(CFG_FLOW_THRESHOLD, THRESH_SET[ph]);
      if (ph == 4) begin
        write_reg(CFG_SPARE_LO, 6'h3F);
        write_reg(CFG_SPARE_HI, 6'h2A);
      end

      if (ph == 0) begin
        send_event(OP_POP, 8'hFF, 0);       // pop with receive FIFO empty
        send_event(OP_TX_READY, 8'h00, 0);  // XON pending out of reset
        send_event(OP_TX_READY, 8'hFF, 0);  // nothing left: request drops
        send_event(OP_WRITE, 8'h00, 0);
        send_event(OP_WRITE, 8'hFF, 0);
        send_event(OP_TX_READY, 8'h00, 0);
        send_event(OP_TX_READY, 8'h00, 0);
        send_event(OP_TX_READY, 8'h00, 0);
        send_event(OP_RX_BYTE, 8'h00, 0);
        send_event(OP_RX_BYTE, 8'hFF, 0);
        send_event(OP_RX_BYTE, 8'h5A, 0);
        send_event(OP_POP, 8'h00, 0);
        send_event(OP_POP, 8'h00, 0);
        send_event(OP_POP, 8'h00, 0);
        send_event(OP_POP, 8'h00, 0);
      end else if (ph == 1) begin
        // threshold at its top: one received byte asks for XOFF, one pop XON
        send_event(OP_RX_BYTE, 8'hA5, 0);
        send_event(OP_TX_READY, 8'h00, 0);
        send_event(OP_POP, 8'h00, 0);
        send_event(OP_TX_READY, 8'h00, 0);
        send_event(OP_TX_READY, 8'h00, 0);
      end

      random_events(RANDOM_PER_PHASE);
    end

    drain(8);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
